@@ design/bitmap_block_allocator_defines.svh @@
// Assertion macros used by the bitmap block allocator datapath.
`ifndef BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle while arst_n is low
`define BBA_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bitmap allocator check failed");

// Next-cycle implication, sampled on clk, idle while arst_n is low
`define BBA_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bitmap allocator sequence check failed");

`endif

@@ design/bba_pkg.sv @@
// Package: sizes, codes and controller/datapath interface types of the block allocator.
`default_nettype none
package bba_pkg;

	localparam int MAX_BLOCKS = 4096;
	localparam int WORD_BITS  = 32;
	localparam int MAP_WORDS  = MAX_BLOCKS / WORD_BITS;
	localparam int WORD_IDX_W = $clog2(MAP_WORDS);
	localparam int BIT_IDX_W  = $clog2(WORD_BITS);
	localparam int BLK_W      = 12;
	localparam int CFG_W      = 13;
	// word index of the limit, wide enough to hold MAP_WORDS itself
	localparam int LIM_WORD_W = CFG_W - BIT_IDX_W;

	localparam logic [CFG_W-1:0] TOTAL_BLOCKS_RST = CFG_W'(4096);

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_ALLOC = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic start;     // latch request beat, aim read port
		logic scan;      // check one map word of an allocate search
		logic free_chk;  // check and update the word of a free
		logic load_out;  // move result into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic kind_free;  // current request is a free
		logic scan_done;  // search hit a clear bit or ran out of words
		logic out_ready;  // output register can take a result
	} sts_t;

endpackage
`default_nettype wire

@@ design/bba_datapath.sv @@
// Datapath: allocation map memory, word scan, bit update, result and output registers.
`default_nettype none
`include "bitmap_block_allocator_defines.svh"
module bba_datapath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire bba_pkg::cmd_t                cmd,
	output bba_pkg::sts_t                     sts,
	input  wire logic                         kind,
	input  wire logic [bba_pkg::BLK_W-1:0]    block_number,
	input  wire logic                         total_blocks_we,
	input  wire logic [bba_pkg::CFG_W-1:0]    total_blocks_wdata,
	output logic                              rsp_valid,
	input  wire logic                         rsp_stall,
	output logic [1:0]                        status,
	output logic [bba_pkg::BLK_W-1:0]         block_number_res
);

	logic [bba_pkg::WORD_BITS-1:0]  mem [bba_pkg::MAP_WORDS];
	logic [bba_pkg::MAP_WORDS-1:0]  row_vld_q;
	logic [bba_pkg::WORD_IDX_W-1:0] addr_q;
	logic [bba_pkg::WORD_IDX_W-1:0] chk_q;
	logic [bba_pkg::WORD_BITS-1:0]  rd_word_q;
	logic                           rd_vld_q;
	logic                           kind_q;
	logic [bba_pkg::BLK_W-1:0]      blk_q;
	logic [bba_pkg::CFG_W-1:0]      total_blocks_q;
	logic [bba_pkg::CFG_W-1:0]      limit;
	logic [bba_pkg::LIM_WORD_W-1:0] lim_word;
	logic [bba_pkg::LIM_WORD_W-1:0] lim_ceil;
	logic [bba_pkg::LIM_WORD_W-1:0] chk_ext;
	logic [bba_pkg::LIM_WORD_W-1:0] chk_next;
	logic [bba_pkg::BIT_IDX_W-1:0]  lim_bit;
	logic [bba_pkg::BIT_IDX_W-1:0]  free_bit;
	logic [bba_pkg::BIT_IDX_W-1:0]  blk_bit;
	logic [bba_pkg::WORD_BITS-1:0]  word;
	logic [bba_pkg::WORD_BITS-1:0]  valid_mask;
	logic [bba_pkg::WORD_BITS-1:0]  free_mask;
	logic [bba_pkg::WORD_BITS-1:0]  wr_data;
	logic                           hit;
	logic                           last;
	logic                           in_range;
	logic                           blk_set;
	logic                           we;
	bba_pkg::status_t               res_status_q;
	logic [bba_pkg::BLK_W-1:0]      res_blk_q;
	logic                           out_vld_q;
	bba_pkg::status_t               out_status_q;
	logic [bba_pkg::BLK_W-1:0]      out_blk_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_blocks_q <= bba_pkg::TOTAL_BLOCKS_RST;
		end else if (total_blocks_we) begin
			total_blocks_q <= total_blocks_wdata;
		end
	end

	// Search limit, saturated to the map size, split into word and bit
	always_comb begin
		if (total_blocks_q > bba_pkg::CFG_W'(bba_pkg::MAX_BLOCKS)) begin
			limit = bba_pkg::CFG_W'(bba_pkg::MAX_BLOCKS);
		end else begin
			limit = total_blocks_q;
		end
		lim_word = limit[bba_pkg::CFG_W-1:bba_pkg::BIT_IDX_W];
		lim_bit  = limit[bba_pkg::BIT_IDX_W-1:0];
		lim_ceil = lim_word + bba_pkg::LIM_WORD_W'(lim_bit != '0);
	end

	// Request latch and read address; chk_q is addr_q registered,
	// matching the registered read data
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q <= kind;
			blk_q  <= block_number;
			if (kind == bba_pkg::KIND_FREE) begin
				addr_q <= block_number[bba_pkg::BLK_W-1:bba_pkg::BIT_IDX_W];
			end else begin
				addr_q <= '0;
			end
		end else begin
			addr_q <= addr_q + bba_pkg::WORD_IDX_W'(1);
		end
		chk_q <= addr_q;
	end

	// Map memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[chk_q] <= wr_data;
		end
		rd_word_q <= mem[addr_q];
	end

	// Row valid bits: a row never written reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			rd_vld_q <= row_vld_q[addr_q];
			if (we) begin
				row_vld_q[chk_q] <= 1'b1;
			end
		end
	end

	assign word = rd_vld_q ? rd_word_q : '0;

	// Bits of the checked word that lie below the limit
	always_comb begin
		chk_ext = bba_pkg::LIM_WORD_W'(chk_q);
		for (int b = 0; b < bba_pkg::WORD_BITS; b++) begin
			valid_mask[b] = (chk_ext < lim_word) ||
				((chk_ext == lim_word) && (bba_pkg::BIT_IDX_W'(b) < lim_bit));
		end
	end

	// Lowest clear bit in range
	always_comb begin
		free_mask = ~word & valid_mask;
		hit       = |free_mask;
		free_bit  = '0;
		for (int b = bba_pkg::WORD_BITS - 1; b >= 0; b--) begin
			if (free_mask[b]) begin
				free_bit = bba_pkg::BIT_IDX_W'(b);
			end
		end
	end

	assign chk_next = chk_ext + bba_pkg::LIM_WORD_W'(1);
	assign last     = chk_next >= lim_ceil;

	// Free checks
	assign blk_bit  = blk_q[bba_pkg::BIT_IDX_W-1:0];
	assign in_range = bba_pkg::CFG_W'(blk_q) < limit;
	assign blk_set  = word[blk_bit];

	// Map update
	always_comb begin
		we = (cmd.scan && hit) || (cmd.free_chk && in_range && blk_set);
		if (cmd.scan) begin
			wr_data = word | (bba_pkg::WORD_BITS'(1) << free_bit);
		end else begin
			wr_data = word & ~(bba_pkg::WORD_BITS'(1) << blk_bit);
		end
	end

	// Result capture
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			if (hit) begin
				res_status_q <= bba_pkg::ST_OK;
				res_blk_q    <= {chk_q, free_bit};
			end else if (last) begin
				res_status_q <= bba_pkg::ST_FULL;
				res_blk_q    <= '0;
			end
		end else if (cmd.free_chk) begin
			res_blk_q <= blk_q;
			if (!in_range) begin
				res_status_q <= bba_pkg::ST_RANGE;
			end else if (!blk_set) begin
				res_status_q <= bba_pkg::ST_NOT_ALLOC;
			end else begin
				res_status_q <= bba_pkg::ST_OK;
			end
		end
	end

	// Output register: holds the result beat until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_blk_q    <= res_blk_q;
		end
	end

	assign rsp_valid        = out_vld_q;
	assign status           = out_status_q;
	assign block_number_res = out_blk_q;

	assign sts.kind_free = kind_q;
	assign sts.scan_done = hit || last;
	assign sts.out_ready = !out_vld_q || !rsp_stall;

	`BBA_ASSERT_IMPL(a_load_when_free, cmd.load_out, sts.out_ready)
	`BBA_ASSERT_IMPL(a_full_gives_zero, out_vld_q && (out_status_q == bba_pkg::ST_FULL), out_blk_q == '0)
	`BBA_ASSERT_IMPL(a_write_in_range, we, chk_ext < lim_ceil)
	`BBA_ASSERT_NEXT(a_scan_advances, cmd.scan && !sts.scan_done, chk_q == $past(chk_q) + 1'b1)

endmodule
`default_nettype wire

@@ design/bba_ctrl.sv @@
// Controller: request sequencing state machine of the block allocator.
`default_nettype none
module bba_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	output bba_pkg::cmd_t      cmd,
	input  wire bba_pkg::sts_t sts
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_FILL = 5'b00010,
		S_SCAN = 5'b00100,
		S_FCHK = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_nxt    = state_q;
		cmd          = '0;
		req_stall    = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.start = 1'b1;
					state_nxt = S_FILL;
				end
			end
			S_FILL: begin
				// first map word is in flight from the memory
				state_nxt = sts.kind_free ? S_FCHK : S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_nxt = S_DONE;
				end
			end
			S_FCHK: begin
				cmd.free_chk = 1'b1;
				state_nxt    = S_DONE;
			end
			S_DONE: begin
				if (sts.out_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ design/bitmap_block_allocator.sv @@
// Top level of the bitmap first-fit block allocator.
//
// Request channel: req_valid/req_stall carry one beat of kind (0 allocate,
// 1 free) and block_number (the block to free; ignored by an allocate).
// Response channel: rsp_valid/rsp_stall carry status and block_number_res.
// A beat moves on a clock edge with valid high and stall low.
// total_blocks_we/total_blocks_wdata write the managed block count; write
// it only while no request is outstanding.
// A free checks the single map word that holds its block; an allocate
// checks words from word 0 upward until it meets a clear bit below the limit
// or runs out of words, at most the 128 words of the map. The search
// checks one map word per cycle through the single read port of the map
// memory, and one request is worked at a time; a new request is taken the
// cycle after the previous result enters the output register.
// Reset (arst_n low) marks every block free through per-word valid bits,
// so the block takes requests right after reset with no clearing pass,
// and total_blocks returns to 4096.
// While the receiver stalls, the response holds in the output register;
// the next request is still worked and then waits for the register.
`default_nettype none
module bitmap_block_allocator (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      req_valid,
	output logic                           req_stall,
	input  wire logic                      kind,
	input  wire logic [bba_pkg::BLK_W-1:0] block_number,
	output logic                           rsp_valid,
	input  wire logic                      rsp_stall,
	output logic [1:0]                     status,
	output logic [bba_pkg::BLK_W-1:0]      block_number_res,
	input  wire logic                      total_blocks_we,
	input  wire logic [bba_pkg::CFG_W-1:0] total_blocks_wdata
);

	bba_pkg::cmd_t cmd;
	bba_pkg::sts_t sts;

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	bba_datapath u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.kind               (kind),
		.block_number       (block_number),
		.total_blocks_we    (total_blocks_we),
		.total_blocks_wdata (total_blocks_wdata),
		.rsp_valid          (rsp_valid),
		.rsp_stall          (rsp_stall),
		.status             (status),
		.block_number_res   (block_number_res)
	);

endmodule
`default_nettype wire
